@@ sv/ssw_pkg.sv @@
// ----------------------------------------------------------------------------
// ssw_pkg: shared types for the signed sum ways counter
// Holds the sequencer state type used by the top level.
// ----------------------------------------------------------------------------
package ssw_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_PUSH
  } ssw_state_t;

endpackage

@@ sv/ssw_ram.sv @@
// ----------------------------------------------------------------------------
// ssw_ram: generic RAM with one write port and two registered read ports
// Read data shows up one cycle after the address is presented.
// ----------------------------------------------------------------------------
module ssw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2047
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr0,
  output logic [WIDTH-1:0]         rd_data0,
  input  logic [$clog2(DEPTH)-1:0] rd_addr1,
  output logic [WIDTH-1:0]         rd_data1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

@@ sv/signed_sum_ways_counter.sv @@
// ----------------------------------------------------------------------------
// signed_sum_ways_counter: counts sign assignments that reach a target sum
// Sweeps a two-bank table of counts once per number of a set.
// ----------------------------------------------------------------------------
// Each accepted item (one number of a set) is taken while the block is idle,
// and no further item is taken until its work is done. The sweep issues one
// table entry per cycle over all DEPTH = 2*SUM_LIMIT+1 entries through the
// two read ports of the active bank memory and the single adder, and a
// drain step writes the final entry into the other bank. An item marked last
// adds a push step in which the result item is loaded into the output
// register, and that step waits while an earlier result still sits in that
// register untaken. The output register holds a result until it is taken,
// and the block returns to accepting items as soon as the
// result is loaded. The result
// gives the count at the target sum (zero when the target lies outside the
// table) and an error flag that is set when the running total went above
// SUM_LIMIT or the set held more than MAX_ITEMS numbers. Counts wrap modulo
// 2^COUNT_WIDTH and the result carries their low 32 bits. No clearing pass is
// needed between sets: the first number of a set reads a fresh table (a one
// at sum zero) in place of memory, and every sweep rewrites the whole
// destination bank. The target register may be written only while idle.
module signed_sum_ways_counter #(
  parameter int SUM_LIMIT   = 1023,
  parameter int MAX_ITEMS   = 31,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [9:0]  in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_ways,
  output logic        out_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ssw_pkg::*;

  localparam int DEPTH = 2 * SUM_LIMIT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = 10;
  localparam int SW    = ((AW > 11) ? AW : 11) + 3;
  localparam int TOTW  = $clog2(SUM_LIMIT + 2);
  localparam int ADDW  = ((TOTW > VW) ? TOTW : VW) + 1;
  localparam int ITW   = $clog2(MAX_ITEMS + 2);

  localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic signed [SW-1:0] LIMIT_S = SW'(SUM_LIMIT);
  localparam logic [AW-1:0]        LAST_J  = AW'(DEPTH - 1);
  localparam logic [ADDW-1:0]      LIMIT_A = ADDW'(SUM_LIMIT);
  localparam logic [ITW-1:0]       ITEMS_M = ITW'(MAX_ITEMS);

  // Configuration register.
  logic signed [10:0] target_r;
  logic               cfg_wr;

  // Sequencer and per-set state.
  ssw_state_t         state_r, state_nxt;
  logic [AW-1:0]      j_r;
  logic [VW-1:0]      v_r;
  logic               last_r;
  logic               bank_r;
  logic               first_r;
  logic [TOTW-1:0]    total_r;
  logic [ITW-1:0]     items_r;
  logic               ovf_r;
  logic [COUNT_WIDTH-1:0] cap_r;

  // Write stage of the sweep pipeline.
  logic               wr_vld_r;
  logic [AW-1:0]      wr_idx_r;
  logic               lo_ok_r, hi_ok_r, lo_one_r, hi_one_r;

  // Output register.
  logic               out_valid_r;
  logic [31:0]        out_ways_r;
  logic               out_error_r;

  logic               in_acc;
  logic               load_out;
  logic signed [SW-1:0] lo_s, hi_s, tgt_s;
  logic               lo_ok, hi_ok, tgt_ok;
  logic [AW-1:0]      lo_addr, hi_addr;
  logic [COUNT_WIDTH-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
  logic [COUNT_WIDTH-1:0] src_lo, src_hi, term_lo, term_hi, sum;
  logic               we_a, we_b;
  logic [ADDW-1:0]    total_sum;
  logic [TOTW-1:0]    total_nxt;
  logic [ITW-1:0]     items_nxt;
  logic               ovf_nxt;
  logic [63:0]        cap_ext;

  // --------------------------------------------------------------------------
  // APB register: the target sum sits at byte address 0.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(target_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr) begin
      target_r <= signed'(pwdata[10:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes and sequencer.
  // --------------------------------------------------------------------------
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_out  = (state_r == S_PUSH) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;
  assign out_error = out_error_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (j_r == LAST_J) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = last_r ? S_PUSH : S_IDLE;
      end
      S_PUSH: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Running total and item count, updated as each item is taken.
  // --------------------------------------------------------------------------
  always_comb begin
    total_sum = ADDW'(total_r) + ADDW'(in_value);
    ovf_nxt   = ovf_r;
    if (total_sum > LIMIT_A) begin
      total_nxt = TOTW'(SUM_LIMIT + 1);
      ovf_nxt   = 1'b1;
    end else begin
      total_nxt = total_sum[TOTW-1:0];
    end
    items_nxt = (items_r <= ITEMS_M) ? items_r + 1'b1 : items_r;
    if (items_nxt > ITEMS_M) ovf_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      items_r <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      first_r <= 1'b1;
    end else begin
      if (in_acc) begin
        total_r <= total_nxt;
        items_r <= items_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (state_r == S_DRAIN) begin
        bank_r  <= ~bank_r;
        first_r <= 1'b0;
      end
      // Loading the result closes the set and starts a fresh one.
      if (load_out) begin
        total_r <= '0;
        items_r <= '0;
        ovf_r   <= 1'b0;
        bank_r  <= 1'b0;
        first_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r    <= in_value;
      last_r <= in_last;
    end
  end

  // --------------------------------------------------------------------------
  // Read stage: entry j takes its two sources at j-v and j+v.
  // --------------------------------------------------------------------------
  always_comb begin
    lo_s    = $signed({{(SW-AW){1'b0}}, j_r}) - $signed({{(SW-VW){1'b0}}, v_r});
    hi_s    = $signed({{(SW-AW){1'b0}}, j_r}) + $signed({{(SW-VW){1'b0}}, v_r});
    lo_ok   = (lo_s >= 0);
    hi_ok   = (hi_s < DEPTH_S);
    lo_addr = lo_ok ? lo_s[AW-1:0] : '0;
    hi_addr = hi_ok ? hi_s[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r      <= '0;
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= (state_r == S_SWEEP);
      if (state_r == S_SWEEP) begin
        j_r <= (j_r == LAST_J) ? '0 : j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r <= j_r;
    lo_ok_r  <= lo_ok;
    hi_ok_r  <= hi_ok;
    lo_one_r <= (lo_s == LIMIT_S);
    hi_one_r <= (hi_s == LIMIT_S);
  end

  // --------------------------------------------------------------------------
  // Write stage: one shared adder forms old[j-v] + old[j+v]. The first number
  // of a set sees a fresh table with a single one at sum zero.
  // --------------------------------------------------------------------------
  always_comb begin
    src_lo  = bank_r ? rd_b0 : rd_a0;
    src_hi  = bank_r ? rd_b1 : rd_a1;
    term_lo = !lo_ok_r ? '0 : (first_r ? COUNT_WIDTH'(lo_one_r) : src_lo);
    term_hi = !hi_ok_r ? '0 : (first_r ? COUNT_WIDTH'(hi_one_r) : src_hi);
    sum     = term_lo + term_hi;
  end

  assign we_a = wr_vld_r && bank_r;
  assign we_b = wr_vld_r && !bank_r;

  ssw_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_bank_a (
    .clk      (clk),
    .wr_en    (we_a),
    .wr_addr  (wr_idx_r),
    .wr_data  (sum),
    .rd_addr0 (lo_addr),
    .rd_data0 (rd_a0),
    .rd_addr1 (hi_addr),
    .rd_data1 (rd_a1)
  );

  ssw_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_bank_b (
    .clk      (clk),
    .wr_en    (we_b),
    .wr_addr  (wr_idx_r),
    .wr_data  (sum),
    .rd_addr0 (lo_addr),
    .rd_data0 (rd_b0),
    .rd_addr1 (hi_addr),
    .rd_data1 (rd_b1)
  );

  // --------------------------------------------------------------------------
  // The entry at the target is caught as it is written, so the result needs
  // no extra read. A target outside the table leaves the capture at zero.
  // --------------------------------------------------------------------------
  assign tgt_s  = SW'(target_r) + LIMIT_S;
  assign tgt_ok = (tgt_s >= 0) && (tgt_s < DEPTH_S);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cap_r <= '0;
    end else if (wr_vld_r && tgt_ok && (wr_idx_r == tgt_s[AW-1:0])) begin
      cap_r <= sum;
    end
  end

  assign cap_ext = 64'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ways_r  <= cap_ext[31:0];
      out_error_r <= ovf_r;
    end
  end

`ifndef SYNTHESIS
  // Only one bank is written at a time.
  a_one_bank_written: assert property (@(posedge clk) disable iff (!rst_n)
    !(we_a && we_b))
    else $error("both table banks written in one cycle");

  // The drain cycle writes the last entry of the table.
  a_drain_last_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |-> (wr_vld_r && (wr_idx_r == LAST_J)))
    else $error("sweep did not end on the last table entry");

  // A completed sweep leaves real counts in memory for the next number.
  a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> !first_r)
    else $error("fresh-table mode still active after a sweep");

  // A result appears only out of the push step.
  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("result item raised outside the push step");
`endif

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the signed sum ways counter
// Feeds sets of numbers through the valid/ready input and checks the ways count
// and error flag of every set against a count-table predictor or a typed result.
// ----------------------------------------------------------------------------
module testbench;

  // Sizes match the default build of the block.
  localparam int SUM_LIM  = 1023;
  localparam int ITEM_LIM = 31;
  localparam int SPAN     = 2 * SUM_LIM + 1;

  // One full sweep of the table plus some margin. The block can still be
  // sweeping a number that produces no result when the last result shows up.
  localparam int SETTLE = SPAN + 64;

  // Cycles the receiver holds off during the back-pressure phase. That is
  // long enough for a result to wait in the output register and a second
  // set to stall behind it.
  localparam int HOLD_CYCLES = 10000;

  // Cycles with no item taken on either side and no register access.
  // The worst case for a correct block is a sender gap plus a full sweep,
  // or the receiver hold-off, so this is several times either one.
  localparam int QUIET_LIMIT = 40000;

  localparam int ITEM_GOAL = 290;

  // Register map. Only index 0 exists, and index 1 is written to check that
  // writes to unused addresses are dropped.
  localparam int TARGET_REG = 0;
  localparam int SPARE_REG  = 1;

  typedef struct packed {
    logic [31:0] ways;
    logic        err;
  } result_t;

  // One row of the directed table. A row with set_tgt writes the target
  // first, while the block is idle. A row with poke_spare also writes the
  // unused register. Rows with typed carry a hand-worked result that is
  // easy to see from the arithmetic. All other rows rely on the predictor.
  typedef struct {
    bit set_tgt;
    int tgt;
    bit poke_spare;
    int value;
    bit last;
    bit typed;
    int ways;
    bit err;
  } dir_row_t;

  localparam int N_DIR = 17;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [9:0]  in_value  = '0;
  logic        in_last   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_ways;
  logic        out_error;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  signed_sum_ways_counter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ways  (out_ways),
    .out_error (out_error),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the count table indexed by partial sum plus SUM_LIM,
  // the running total and number count of the current set, the sticky
  // error flag of the set, and the shadow of the target register.
  // --------------------------------------------------------------------------
  logic [31:0]        ways_at  [SPAN];
  logic [31:0]        ways_nxt [SPAN];
  int unsigned        sum_seen;
  int unsigned        nums_seen;
  bit                 set_bad;
  logic signed [10:0] tgt_reg;

  result_t expected_q [$];
  int      items_in   = 0;
  int      n_bad      = 0;
  int      burst_left = 0;
  bit      hold_req   = 1'b0;

  // A fresh set has exactly one way to reach sum zero and no other sums.
  function automatic void start_fresh_set();
    foreach (ways_at[j]) ways_at[j] = '0;
    ways_at[SUM_LIM] = 32'd1;
    sum_seen  = 0;
    nums_seen = 0;
    set_bad   = 1'b0;
  endfunction

  // Folds one number into the table. Each sum j can be reached from j-v by
  // adding v or from j+v by subtracting it. Sums that fall off either end of
  // the table are dropped, and counts wrap at 32 bits. Returns 1 and fills
  // res when the number closes a set.
  function automatic bit fold_number(input logic [9:0] v, input bit fin,
                                     output result_t res);
    int lo;
    int hi;
    logic [31:0] a;
    logic [31:0] b;
    res = '0;
    for (int j = 0; j < SPAN; j++) begin
      lo = j - int'(v);
      hi = j + int'(v);
      a  = (lo >= 0)   ? ways_at[lo] : '0;
      b  = (hi < SPAN) ? ways_at[hi] : '0;
      ways_nxt[j] = a + b;
    end
    ways_at = ways_nxt;

    // The total saturates just past the limit, and the number count
    // saturates just past its own limit. Both latch the error for the set.
    sum_seen += v;
    if (sum_seen > SUM_LIM) begin
      sum_seen = SUM_LIM + 1;
      set_bad  = 1'b1;
    end
    if (nums_seen <= ITEM_LIM) nums_seen++;
    if (nums_seen > ITEM_LIM) set_bad = 1'b1;

    if (!fin) return 1'b0;

    // The target is looked up only when the set closes. A target of -1024
    // lies one step past the table and reads as zero.
    hi = int'(tgt_reg) + SUM_LIM;
    res.ways = (hi >= 0 && hi < SPAN) ? ways_at[hi] : '0;
    res.err  = set_bad;
    start_fresh_set();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Register write: a setup phase, then an access phase that completes at
  // the edge where pready is high. Then psel goes low before the task
  // returns, so two writes in a row never drive psel twice in the same step.
  // --------------------------------------------------------------------------
  task automatic write_reg(input int idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx << 2);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == TARGET_REG) tgt_reg = data[10:0];
    @(posedge clk);
  endtask

  // Offers one number and waits for the handshake. It returns at the
  // accepting edge with in_valid still high, so the next item can follow
  // at once. The predictor advances on acceptance, and a closing number
  // queues its result. Where the row has a typed result, that value is
  // queued in place of the predictor's.
  task automatic offer(input logic [9:0] v, input bit fin, input bit typed,
                       input logic [31:0] tw, input bit te);
    result_t res;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    items_in++;
    if (fold_number(v, fin, res)) begin
      if (typed) begin
        res.ways = tw;
        res.err  = te;
      end
      expected_q.insert(expected_q.size(), res);
    end
  endtask

  // Drops valid, waits until every pending result has been taken, and then
  // lets a full sweep pass. After that the block is idle and may be
  // reconfigured.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The sender works in bursts. Between bursts it drops valid for a gap
  // that is usually short, sometimes absent, and now and then longer than
  // a sweep, so that gaps land at every point of the block's work.
  task automatic next_slot();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(100, 2500);
        1, 2:    gap = 0;
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // One complete set of len numbers, each drawn from 0..vmax.
  task automatic play_set(input int len, input int vmax);
    for (int i = 0; i < len; i++) begin
      next_slot();
      offer(10'($urandom_range(0, vmax)), i == len - 1, 1'b0, '0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking. Every result taken is matched with the oldest pending
  // expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item: out_ways %0d out_error %0b", out_ways, out_error);
        n_bad++;
      end else begin
        want = expected_q.pop_front();
        if (out_ways !== want.ways) begin
          $error("out_ways: expected %0d, actual %0d", want.ways, out_ways);
          n_bad++;
        end
        if (out_error !== want.err) begin
          $error("out_error: expected %0b, actual %0b", want.err, out_error);
          n_bad++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It works in stretches of random length. Each stretch always
  // takes results, takes about half of them, or stalls most cycles. On
  // request it holds off for HOLD_CYCLES straight.
  // --------------------------------------------------------------------------
  initial begin
    int stretch_left;
    int mode;
    stretch_left = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(1, 64);
          mode = $urandom_range(0, 2);
        end
        stretch_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. A healthy run never goes this long without moving an item or
  // touching the register port.
  // --------------------------------------------------------------------------
  int quiet = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [N_DIR];

  initial begin
    logic signed [10:0] t;
    int n_sets;
    bit squeezed;
    bit wrapped;
    bit long_mixed;
    squeezed   = 1'b0;
    wrapped    = 1'b0;
    long_mixed = 1'b0;

    tgt_reg = '0;
    start_fresh_set();

    dir_rows = '{
      // A zero after reset doubles the single path through sum zero.
      '{1'b0,     0, 1'b0,    0, 1'b1, 1'b1, 2, 1'b0},
      // The largest number alone can only land at +-1023, never at zero.
      '{1'b0,     0, 1'b0, 1023, 1'b1, 1'b1, 0, 1'b0},
      // The top and bottom edges of the table each have exactly one way.
      '{1'b1,  1023, 1'b0, 1023, 1'b1, 1'b1, 1, 1'b0},
      '{1'b1, -1023, 1'b0, 1023, 1'b1, 1'b1, 1, 1'b0},
      // A target one step past the table reads as zero.
      '{1'b1, -1024, 1'b0,    0, 1'b1, 1'b1, 0, 1'b0},
      // A write to the unused register must leave the target at 5.
      '{1'b1,     5, 1'b1,    5, 1'b1, 1'b1, 1, 1'b0},
      // A total of 1024 goes past the sum limit, so the error is set.
      '{1'b1,     0, 1'b0, 1023, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,    1, 1'b1, 1'b1, 0, 1'b1},
      // Negative target with all bits set, and a few ordinary sets.
      '{1'b1,    -1, 1'b0,    3, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,    2, 1'b1, 1'b0, 0, 1'b0},
      '{1'b1,     2, 1'b0,    1, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,    1, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,    1, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,    1, 1'b1, 1'b0, 0, 1'b0},
      '{1'b1,     0, 1'b0,  512, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,  256, 1'b0, 1'b0, 0, 1'b0},
      '{1'b0,     0, 1'b0,  256, 1'b1, 1'b0, 0, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Targets change only at the start of a set, after the
    // block has gone idle.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].set_tgt) begin
        settle_idle();
        if (dir_rows[r].poke_spare) write_reg(SPARE_REG, 32'hFFFF_FFFF);
        write_reg(TARGET_REG, 32'(dir_rows[r].tgt));
        if (dir_rows[r].poke_spare) write_reg(SPARE_REG, 32'h0000_0000);
      end
      offer(10'(dir_rows[r].value), dir_rows[r].last, dir_rows[r].typed,
            32'(dir_rows[r].ways), dir_rows[r].err);
    end

    // Random part, in phases. Each phase starts from idle with a new target.
    // Most targets are near zero so that small sets give nonzero counts.
    // Some use the whole 11-bit field or its extremes.
    while (items_in < ITEM_GOAL) begin
      settle_idle();
      case ($urandom_range(0, 9))
        0: t = 11'($urandom_range(0, 2047));
        1: begin
          case ($urandom_range(0, 4))
            0:       t = 11'h400;
            1:       t = 11'h401;
            2:       t = 11'h3FF;
            3:       t = 11'h7FF;
            default: t = '0;
          endcase
        end
        default: t = 11'(int'($urandom_range(0, 48)) - 24);
      endcase
      write_reg(TARGET_REG, 32'(t));
      if ($urandom_range(0, 7) == 0) write_reg(SPARE_REG, $urandom());

      if (!squeezed && items_in > 120) begin
        // Back-pressure: with the receiver held off, one result fills the
        // output register, the next set finishes its sweep and stalls, and
        // the sender keeps offering behind it.
        squeezed = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 4; i++) offer(10'($urandom_range(0, 15)), 1'b1, 1'b0, '0, 1'b0);
      end else if (!wrapped && items_in > 60) begin
        // Thirty-two zeros: the count at zero reaches 2^32 and wraps to 0,
        // and the set is too long, so the error is set.
        wrapped = 1'b1;
        play_set(32, 0);
      end else if (!long_mixed && items_in > 200) begin
        // A long set of small numbers that runs past the item limit.
        long_mixed = 1'b1;
        play_set(36, 3);
      end else begin
        n_sets = $urandom_range(2, 5);
        for (int s = 0; s < n_sets; s++) begin
          case ($urandom_range(0, 19))
            14, 15:  play_set($urandom_range(1, 4), 1023);
            16, 17:  play_set($urandom_range(1, 12), 100);
            default: play_set($urandom_range(1, 8), 15);
          endcase
        end
      end
    end

    // Drain, then allow one more sweep so that a stray result would show up.
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_bad == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

@@ signed_sum_ways_counter.f @@
sv/ssw_pkg.sv
sv/ssw_ram.sv
sv/signed_sum_ways_counter.sv
dv/testbench.sv
